>>> rtl/tpd_pkg.sv
// Shared types and constants for the phase-angle TRIAC dimmer.
// Used by every module in this folder; depends on nothing.

package tpd_pkg;

	localparam int LevelW = 7;
	localparam int TickW  = 17;
	localparam int CfgW   = 10;
	localparam int CfgIdxW = 3;

	// Command codes carried in the op field of an item.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_ZCROSS = 3'd1;
	localparam logic [2:0] OP_SET   = 3'd2;
	localparam logic [2:0] OP_INC   = 3'd3;
	localparam logic [2:0] OP_DEC   = 3'd4;
	localparam logic [2:0] OP_POWER = 3'd5;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_STEP_TICKS    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PULSE_TICKS   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LEVEL_STEP    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LED_THRESHOLD = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RESTORE_FLOOR = 3'd4;

	// Reset values.
	localparam logic [9:0]        RST_STEP_TICKS    = 10'd78;
	localparam logic [7:0]        RST_PULSE_TICKS   = 8'd10;
	localparam logic [5:0]        RST_LEVEL_STEP    = 6'd5;
	localparam logic [LevelW-1:0] RST_LED_THRESHOLD = 7'd10;
	localparam logic [LevelW-1:0] RST_RESTORE_FLOOR = 7'd20;
	localparam logic [LevelW-1:0] RST_LEVEL         = 7'd45;
	localparam logic [LevelW-1:0] RST_PHASE_STEPS   = 7'd71;

	localparam logic [LevelW-1:0] LEVEL_MAX = 7'd100;

	// 127/100 scaled by 2^16 and rounded up; exact floor for levels up to 100.
	localparam logic [16:0] PHASE_MUL = 17'd83231;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] set_value;
	} tpd_cmd_t;

	typedef struct packed {
		logic              gate;
		logic              led;
		logic [LevelW-1:0] level;
		logic [LevelW-1:0] phase_steps;
	} tpd_res_t;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic [LevelW-1:0] phase_steps;
	} tpd_level_t;

	// Firing delay in phase steps: 128 - floor(127*level/100), capped at 127.
	function automatic logic [LevelW-1:0] phase_for(input logic [LevelW-1:0] lv);
		logic [23:0] prod;
		logic [7:0]  d;
		prod = 24'(lv) * 24'(PHASE_MUL);
		d = 8'd128 - {1'b0, prod[22:16]};
		phase_for = d[7] ? 7'd127 : d[6:0];
	endfunction

endpackage

>>> rtl/tpd_level.sv
// Brightness level state: set, step, and power toggle with saved level.
// Depends on tpd_pkg.

module tpd_level
	import tpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tpd_cmd_t          cmd,
	input  logic [5:0]        level_step,
	input  logic [LevelW-1:0] restore_floor,
	output logic [LevelW-1:0] phase_cur,
	output tpd_level_t        next
);

	logic [LevelW-1:0] cur_q, saved_q, delay_q;
	logic [LevelW-1:0] lv_new, saved_new, floor_cap, keep;
	logic              upd;
	logic [7:0]        sum;

	assign sum       = {1'b0, cur_q} + {2'b00, level_step};
	assign floor_cap = (restore_floor > LEVEL_MAX) ? LEVEL_MAX : restore_floor;
	assign keep      = (cur_q > floor_cap) ? cur_q : floor_cap;

	always_comb begin
		upd       = 1'b1;
		lv_new    = cur_q;
		saved_new = cur_q;
		case (cmd.op)
			OP_SET: begin
				if (cmd.set_value < 16'sd0)
					lv_new = '0;
				else if (cmd.set_value > 16'sd100)
					lv_new = LEVEL_MAX;
				else
					lv_new = cmd.set_value[LevelW-1:0];
				saved_new = lv_new;
			end
			OP_INC: begin
				lv_new    = (sum > 8'(LEVEL_MAX)) ? LEVEL_MAX : sum[LevelW-1:0];
				saved_new = lv_new;
			end
			OP_DEC: begin
				lv_new    = ({1'b0, cur_q} < {2'b00, level_step}) ? '0 :
					7'({1'b0, cur_q} - {2'b00, level_step});
				saved_new = lv_new;
			end
			OP_POWER: begin
				if (cur_q != '0) begin
					lv_new    = '0;
					saved_new = keep;
				end else begin
					lv_new    = (saved_q > LEVEL_MAX) ? LEVEL_MAX : saved_q;
					saved_new = lv_new;
				end
			end
			default: begin
				upd = 1'b0;
			end
		endcase
	end

	assign next.level       = lv_new;
	assign next.phase_steps = upd ? phase_for(lv_new) : delay_q;
	assign phase_cur        = delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= RST_LEVEL;
			saved_q <= RST_LEVEL;
			delay_q <= RST_PHASE_STEPS;
		end else if (accept && upd) begin
			cur_q   <= lv_new;
			saved_q <= saved_new;
			delay_q <= next.phase_steps;
		end
	end

endmodule

>>> rtl/tpd_fire.sv
// Firing sequencer: zero-cross delay countdown followed by the gate pulse.
// Depends on tpd_pkg.

module tpd_fire
	import tpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [2:0]        op,
	input  logic [LevelW-1:0] phase_steps,
	input  logic [9:0]        step_ticks,
	input  logic [7:0]        pulse_ticks,
	output logic              gate_next
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DELAY,
		PH_PULSE
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [TickW-1:0] tick_q, tick_d;
	logic [TickW-1:0] delay_ticks;

	assign delay_ticks = TickW'(phase_steps) * TickW'(step_ticks);

	// A count of zero or one both end the current phase on the next tick.
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		case (op)
			OP_TICK: begin
				case (phase_q)
					PH_DELAY: begin
						if (tick_q > TickW'(1)) begin
							tick_d = tick_q - TickW'(1);
						end else begin
							phase_d = PH_PULSE;
							tick_d  = TickW'(pulse_ticks);
						end
					end
					PH_PULSE: begin
						if (tick_q > TickW'(1)) begin
							tick_d = tick_q - TickW'(1);
						end else begin
							phase_d = PH_IDLE;
							tick_d  = '0;
						end
					end
					default: begin
					end
				endcase
			end
			OP_ZCROSS: begin
				if (phase_q != PH_DELAY && phase_q != PH_PULSE) begin
					phase_d = PH_DELAY;
					tick_d  = delay_ticks;
				end
			end
			default: begin
			end
		endcase
	end

	assign gate_next = (phase_d == PH_PULSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

endmodule

>>> rtl/triac_phase_dimmer_top.sv
// Results are registered; a result lands in the skid register while another waits.
// One item per cycle when not stalled; the level and firing state update in one pass.
// A two-entry output (result register plus skid register) keeps input flowing
// while a result waits; cmd_stall rises only when both entries are full.
// Reset (arst_n low) restores level 45, phase 71, idle firing and default registers.

module triac_phase_dimmer_top
	import tpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  tpd_cmd_t           cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output tpd_res_t           res,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	logic [9:0]        step_ticks_q;
	logic [7:0]        pulse_ticks_q;
	logic [5:0]        level_step_q;
	logic [LevelW-1:0] led_threshold_q;
	logic [LevelW-1:0] restore_floor_q;

	logic              accept, take;
	logic              gate_next;
	logic [LevelW-1:0] phase_cur;
	tpd_level_t        lvl_next;
	tpd_res_t          res_new;
	tpd_res_t          res_q, skid_q;
	logic              res_valid_q, skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q    <= RST_STEP_TICKS;
			pulse_ticks_q   <= RST_PULSE_TICKS;
			level_step_q    <= RST_LEVEL_STEP;
			led_threshold_q <= RST_LED_THRESHOLD;
			restore_floor_q <= RST_RESTORE_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_TICKS:    step_ticks_q    <= cfg_data[9:0];
				REG_PULSE_TICKS:   pulse_ticks_q   <= cfg_data[7:0];
				REG_LEVEL_STEP:    level_step_q    <= cfg_data[5:0];
				REG_LED_THRESHOLD: led_threshold_q <= cfg_data[LevelW-1:0];
				REG_RESTORE_FLOOR: restore_floor_q <= cfg_data[LevelW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cmd_stall = skid_valid_q;
	assign accept    = cmd_valid && !skid_valid_q;
	assign take      = res_valid_q && !res_stall;

	tpd_level u_level (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.level_step    (level_step_q),
		.restore_floor (restore_floor_q),
		.phase_cur     (phase_cur),
		.next          (lvl_next)
	);

	// Zero-cross never changes the level, so the latched phase is the right one.
	tpd_fire u_fire (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (cmd.op),
		.phase_steps (phase_cur),
		.step_ticks  (step_ticks_q),
		.pulse_ticks (pulse_ticks_q),
		.gate_next   (gate_next)
	);

	assign res_new.gate        = gate_next;
	assign res_new.led         = (lvl_next.level > led_threshold_q);
	assign res_new.level       = lvl_next.level;
	assign res_new.phase_steps = lvl_next.phase_steps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!res_valid_q || take) begin
					res_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				res_q <= skid_q;
			end
		end else if (accept) begin
			if (!res_valid_q || take) begin
				res_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_skid_implies_res: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid entry held without a result in front of it");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted item produced no result");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.level <= LEVEL_MAX))
		else $error("result level above 100");

	a_phase_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.phase_steps != '0))
		else $error("result phase count is zero");

endmodule
